### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pose interpolator RTL.
// Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define TPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tpi_pkg.sv
// ---------------------------------------------------------------------------
// tpi_pkg
// Types, codes and the control store of the pose interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package tpi_pkg;

  localparam int HISTORY_DEPTH_DEF = 32;
  localparam int RATIO_BITS_DEF    = 16;

  localparam int TIME_W   = 63;
  localparam int POS_W    = 32;
  localparam int STATUS_W = 2;
  localparam int AXES     = 3;
  localparam int AX_W     = 2;
  localparam int PC_W     = 4;

  typedef enum logic {
    KIND_PUSH  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INTERP = 2'd0,
    ST_STORED = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_READ,
    OP_SCAN,
    OP_DIVSET,
    OP_DIV,
    OP_MUL,
    OP_ACC,
    OP_EMIT
  } op_t;

  // how the step counter moves on
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ACCEPT,
    COND_SCAN,
    COND_DIV,
    COND_AXIS,
    COND_EMIT
  } cond_t;

  typedef enum logic [1:0] {
    SRC_INTERP,
    SRC_STORED,
    SRC_EMPTY
  } src_t;

  localparam logic [PC_W-1:0] PC_ACCEPT   = 4'd0;
  localparam logic [PC_W-1:0] PC_READ     = 4'd1;
  localparam logic [PC_W-1:0] PC_SCAN     = 4'd2;
  localparam logic [PC_W-1:0] PC_DIVSET   = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV      = 4'd4;
  localparam logic [PC_W-1:0] PC_MUL      = 4'd5;
  localparam logic [PC_W-1:0] PC_ACC      = 4'd6;
  localparam logic [PC_W-1:0] PC_EMIT_INT = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT_STO = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT_EMP = 4'd9;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    src_t            src;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [TIME_W-1:0]       time_ns;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } entry_t;

  // Control store. COND_ACCEPT: empty query jumps to target.
  // COND_SCAN: keep scanning at target, or go to PC_EMIT_STO for a stored result.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_ACCEPT:   w = '{op: OP_ACCEPT, cond: COND_ACCEPT, src: SRC_EMPTY,
                         target: PC_EMIT_EMP};
      PC_READ:     w = '{op: OP_READ, cond: COND_NEXT, src: SRC_STORED,
                         target: PC_ACCEPT};
      PC_SCAN:     w = '{op: OP_SCAN, cond: COND_SCAN, src: SRC_STORED,
                         target: PC_READ};
      PC_DIVSET:   w = '{op: OP_DIVSET, cond: COND_NEXT, src: SRC_INTERP,
                         target: PC_ACCEPT};
      PC_DIV:      w = '{op: OP_DIV, cond: COND_DIV, src: SRC_INTERP,
                         target: PC_ACCEPT};
      PC_MUL:      w = '{op: OP_MUL, cond: COND_NEXT, src: SRC_INTERP,
                         target: PC_ACCEPT};
      PC_ACC:      w = '{op: OP_ACC, cond: COND_AXIS, src: SRC_INTERP,
                         target: PC_MUL};
      PC_EMIT_INT: w = '{op: OP_EMIT, cond: COND_EMIT, src: SRC_INTERP,
                         target: PC_ACCEPT};
      PC_EMIT_STO: w = '{op: OP_EMIT, cond: COND_EMIT, src: SRC_STORED,
                         target: PC_ACCEPT};
      PC_EMIT_EMP: w = '{op: OP_EMIT, cond: COND_EMIT, src: SRC_EMPTY,
                         target: PC_ACCEPT};
      default:     w = '{op: OP_ACCEPT, cond: COND_ACCEPT, src: SRC_EMPTY,
                         target: PC_EMIT_EMP};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/timestamped_pose_interpolator.sv
// Timestamped pose interpolator. Keeps a ring of HISTORY_DEPTH timestamped
// Q16.16 positions; a push word stores one sample (overwriting the oldest
// when full) and gives no result. A query word scans from the
// oldest entry for the first one not before the query time and returns the
// position interpolated between it and its predecessor (status 0), the
// stored entry when the query lies outside the span (status 1), or zeros
// with status 2 when the history is empty. The scan reads the history
// memory once per entry scanned (1 to HISTORY_DEPTH entries), the ratio
// comes from a restoring divider one bit per step, and one shared
// multiplier serves the three axes in turn. A result waiting at the output
// holds the sequencer on its emit step.
// ---------------------------------------------------------------------------
// timestamped_pose_interpolator
// Microcoded ring history with linear interpolation by time.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module timestamped_pose_interpolator #(
  parameter int HISTORY_DEPTH = tpi_pkg::HISTORY_DEPTH_DEF,
  parameter int RATIO_BITS    = tpi_pkg::RATIO_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_kind,
  input  wire logic [tpi_pkg::TIME_W-1:0]         in_time_ns,
  input  wire logic signed [tpi_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic signed [tpi_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic signed [tpi_pkg::POS_W-1:0]   in_pos_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [tpi_pkg::POS_W-1:0]        out_x,
  output logic signed [tpi_pkg::POS_W-1:0]        out_y,
  output logic signed [tpi_pkg::POS_W-1:0]        out_z,
  output logic [tpi_pkg::STATUS_W-1:0]            out_status
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int DCW    = $clog2(RATIO_BITS);
  localparam int POS_W  = tpi_pkg::POS_W;
  localparam int TIME_W = tpi_pkg::TIME_W;
  localparam int PROD_W = POS_W + RATIO_BITS + 2;
  localparam int PC_W   = tpi_pkg::PC_W;
  localparam int AX_W   = tpi_pkg::AX_W;

  // sequencer
  logic [PC_W-1:0]     pc_r, pc_nxt;
  tpi_pkg::uword_t     uw;

  // ring bookkeeping
  logic [AW-1:0]       oldest_r, oldest_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [DCW-1:0]      dcnt_r, dcnt_nxt;
  logic [AX_W-1:0]     ax_r, ax_nxt;
  logic                out_valid_r, out_valid_nxt;

  // history memory and datapath
  tpi_pkg::entry_t     mem [HISTORY_DEPTH];
  tpi_pkg::entry_t     rd_r;
  tpi_pkg::entry_t     prev_r;
  logic [TIME_W-1:0]   q_r;
  logic [TIME_W-1:0]   den_r;
  logic [TIME_W-1:0]   rem_r;
  logic [RATIO_BITS-1:0] quo_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [POS_W-1:0]  res_r [tpi_pkg::AXES];
  logic signed [POS_W-1:0]  out_x_r, out_y_r, out_z_r;
  logic [tpi_pkg::STATUS_W-1:0] out_status_r;

  logic                in_acc, is_push, push, query, empty, full;
  logic [AW-1:0]       wr_slot, rd_slot;
  logic [CW-1:0]       idx_inc;
  logic                later, scan_more, scan_stored;
  logic                dcnt_last, ax_last, out_load, emit_go;
  logic [TIME_W:0]     rem_sh, rem_sub;
  logic                fits;
  logic signed [POS_W-1:0]  cur_ax, prev_ax, res_nxt;
  logic signed [POS_W:0]    diff;
  logic signed [PROD_W-1:0] rnd, shifted;
  logic signed [POS_W-1:0]  em_x, em_y, em_z;
  logic [tpi_pkg::STATUS_W-1:0] em_status;

  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                              input logic [AW-1:0] age);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, age};
    if (s >= (AW+1)'(HISTORY_DEPTH)) begin
      s = s - (AW+1)'(HISTORY_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign uw       = tpi_pkg::ucode_rom(pc_r);
  assign in_stall = (uw.op != tpi_pkg::OP_ACCEPT);
  assign in_acc   = in_valid && !in_stall;
  assign is_push  = (in_kind == tpi_pkg::KIND_PUSH);
  assign push     = in_acc && is_push;
  assign query    = in_acc && !is_push;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(HISTORY_DEPTH));
  assign wr_slot  = full ? oldest_r : ring_slot(oldest_r, count_r[AW-1:0]);
  assign rd_slot  = ring_slot(oldest_r, idx_r);

  assign idx_inc     = CW'(idx_r) + CW'(1);
  assign later       = (q_r > rd_r.time_ns);
  assign scan_more   = (idx_inc < count_r) && later;
  assign scan_stored = (idx_r == '0) || later;
  assign dcnt_last   = (dcnt_r == DCW'(RATIO_BITS - 1));
  assign ax_last     = (ax_r == AX_W'(tpi_pkg::AXES - 1));
  assign out_load    = !out_valid_r || !out_stall;
  assign emit_go     = (uw.op == tpi_pkg::OP_EMIT) && out_load;

  // restoring divider, one quotient bit per step
  assign rem_sh  = {rem_r, 1'b0};
  assign fits    = (rem_sh >= {1'b0, den_r});
  assign rem_sub = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;

  always_comb begin
    unique case (ax_r)
      2'd0: begin
        cur_ax  = rd_r.x;
        prev_ax = prev_r.x;
      end
      2'd1: begin
        cur_ax  = rd_r.y;
        prev_ax = prev_r.y;
      end
      default: begin
        cur_ax  = rd_r.z;
        prev_ax = prev_r.z;
      end
    endcase
  end

  assign diff    = {prev_ax[POS_W-1], prev_ax} - {cur_ax[POS_W-1], cur_ax};
  // round to nearest, ties up; arithmetic shift is the floor
  assign rnd     = prod_r + PROD_W'(2 ** (RATIO_BITS - 1));
  assign shifted = rnd >>> RATIO_BITS;
  assign res_nxt = cur_ax + shifted[POS_W-1:0];

  always_comb begin
    unique case (uw.src)
      tpi_pkg::SRC_INTERP: begin
        em_x      = res_r[0];
        em_y      = res_r[1];
        em_z      = res_r[2];
        em_status = tpi_pkg::ST_INTERP;
      end
      tpi_pkg::SRC_STORED: begin
        em_x      = rd_r.x;
        em_y      = rd_r.y;
        em_z      = rd_r.z;
        em_status = tpi_pkg::ST_STORED;
      end
      default: begin
        em_x      = '0;
        em_y      = '0;
        em_z      = '0;
        em_status = tpi_pkg::ST_EMPTY;
      end
    endcase
  end

  // step counter
  always_comb begin
    unique case (uw.cond)
      tpi_pkg::COND_NEXT: pc_nxt = pc_r + PC_W'(1);
      tpi_pkg::COND_ACCEPT: begin
        if (query) begin
          pc_nxt = empty ? uw.target : pc_r + PC_W'(1);
        end else begin
          pc_nxt = tpi_pkg::PC_ACCEPT;
        end
      end
      tpi_pkg::COND_SCAN: begin
        if (scan_more) begin
          pc_nxt = uw.target;
        end else if (scan_stored) begin
          pc_nxt = tpi_pkg::PC_EMIT_STO;
        end else begin
          pc_nxt = pc_r + PC_W'(1);
        end
      end
      tpi_pkg::COND_DIV:  pc_nxt = dcnt_last ? pc_r + PC_W'(1) : pc_r;
      tpi_pkg::COND_AXIS: pc_nxt = ax_last ? pc_r + PC_W'(1) : uw.target;
      tpi_pkg::COND_EMIT: pc_nxt = out_load ? uw.target : pc_r;
      default:            pc_nxt = tpi_pkg::PC_ACCEPT;
    endcase
  end

  // control registers next values
  always_comb begin
    count_nxt     = count_r;
    oldest_nxt    = oldest_r;
    idx_nxt       = idx_r;
    dcnt_nxt      = dcnt_r;
    ax_nxt        = ax_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (push) begin
      if (full) begin
        oldest_nxt = ring_slot(oldest_r, AW'(1));
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (query) begin
      idx_nxt = '0;
    end
    if (uw.op == tpi_pkg::OP_SCAN && scan_more) begin
      idx_nxt = idx_r + AW'(1);
    end
    if (uw.op == tpi_pkg::OP_DIVSET) begin
      dcnt_nxt = '0;
      ax_nxt   = '0;
    end
    if (uw.op == tpi_pkg::OP_DIV) begin
      dcnt_nxt = dcnt_r + DCW'(1);
    end
    if (uw.op == tpi_pkg::OP_ACC) begin
      ax_nxt = ax_r + AX_W'(1);
    end
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= tpi_pkg::PC_ACCEPT;
      count_r     <= '0;
      oldest_r    <= '0;
      idx_r       <= '0;
      dcnt_r      <= '0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      idx_r       <= idx_nxt;
      dcnt_r      <= dcnt_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_slot] <= '{time_ns: in_time_ns, x: in_pos_x, y: in_pos_y, z: in_pos_z};
    end
    if (uw.op == tpi_pkg::OP_READ) begin
      rd_r <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (query) begin
      q_r <= in_time_ns;
    end
    if (uw.op == tpi_pkg::OP_SCAN && scan_more) begin
      prev_r <= rd_r;
    end
    if (uw.op == tpi_pkg::OP_DIVSET) begin
      den_r <= rd_r.time_ns - prev_r.time_ns;
      rem_r <= rd_r.time_ns - q_r;
      quo_r <= '0;
    end
    if (uw.op == tpi_pkg::OP_DIV) begin
      rem_r <= rem_sub[TIME_W-1:0];
      quo_r <= {quo_r[RATIO_BITS-2:0], fits};
    end
    if (uw.op == tpi_pkg::OP_MUL) begin
      prod_r <= diff * $signed({1'b0, quo_r});
    end
    if (uw.op == tpi_pkg::OP_ACC) begin
      res_r[ax_r] <= res_nxt;
    end
    if (emit_go) begin
      out_x_r      <= em_x;
      out_y_r      <= em_y;
      out_z_r      <= em_z;
      out_status_r <= em_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_z      = out_z_r;
  assign out_status = out_status_r;

  `TPI_ASSERT(a_count_bound, count_r <= CW'(HISTORY_DEPTH), "entry count above depth")
  `TPI_ASSERT(a_div_range, (uw.op == tpi_pkg::OP_DIV) |-> (den_r != '0 && rem_r < den_r), "divider out of range")
  `TPI_ASSERT_NEXT(a_push_one_cycle, push, pc_r == tpi_pkg::PC_ACCEPT, "push left the accept step")
  `TPI_ASSERT(a_out_from_emit, $rose(out_valid_r) |-> $past(uw.op == tpi_pkg::OP_EMIT), "word shown outside an emit step")

endmodule

`default_nettype wire
